// ----- rtl/i2cra_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cra_pkg
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  // Request codes carried in the op field.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes (byte address divided by four).
  localparam logic [0:0] REG_MAX_ATTEMPTS = 1'b0;
  localparam logic [0:0] REG_PHASE_TICKS  = 1'b1;

  localparam logic [5:0]  MAX_ATTEMPTS_RESET = 6'd20;
  localparam logic [15:0] PHASE_TICKS_RESET  = 16'd200;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified tick as it travels from the front end to the sequencer.
  typedef struct packed {
    logic       start;
    logic       read;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [5:0]  max_attempts;
    logic [15:0] phase_ticks;
  } cfg_t;

endpackage

// ----- rtl/i2cra_front.sv -----
// ----------------------------------------------------------------------------
// i2cra_front
// Input stage: registers each tick and decodes its op into start and read flags.
// ----------------------------------------------------------------------------
module i2cra_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         op,
  input  logic [6:0]         device_addr,
  input  logic [7:0]         reg_addr,
  input  logic [7:0]         write_data,
  input  logic               sda_in,
  output logic               push,
  output i2cra_pkg::item_t   push_item,
  input  logic               queue_full
);

  logic             held;
  i2cra_pkg::item_t item;
  logic             take;

  assign push      = held && !queue_full;
  assign push_item = item;
  assign req_stall = held && queue_full;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Op value three means nothing and is carried as a plain tick.
  always_ff @(posedge clk) begin
    if (take) begin
      item.start       <= (op == i2cra_pkg::OP_WRITE) || (op == i2cra_pkg::OP_READ);
      item.read        <= (op == i2cra_pkg::OP_READ);
      item.device_addr <= device_addr;
      item.reg_addr    <= reg_addr;
      item.write_data  <= write_data;
      item.sda_in      <= sda_in;
    end
  end

endmodule

// ----- rtl/i2cra_queue.sv -----
// ----------------------------------------------------------------------------
// i2cra_queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cra_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cra_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output i2cra_pkg::item_t head
);

  i2cra_pkg::item_t                    slots [i2cra_pkg::QUEUE_DEPTH];
  logic [i2cra_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [i2cra_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [i2cra_pkg::QUEUE_AW:0]        count;

  assign full     = (count == (i2cra_pkg::QUEUE_AW+1)'(i2cra_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/i2cra_back.sv -----
// ----------------------------------------------------------------------------
// i2cra_back
// Bus sequencer: advances the I2C phase timer and bit cells by one tick per
// item and registers the result for the output channel.
// ----------------------------------------------------------------------------
module i2cra_back (
  input  logic             clk,
  input  logic             rst,
  input  i2cra_pkg::cfg_t  cfg,
  input  logic             nonempty,
  input  i2cra_pkg::item_t item,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic             scl_out,
  output logic             sda_out,
  output logic             busy_res,
  output logic             done_res,
  output logic             acked,
  output logic [7:0]       read_data,
  output logic [5:0]       attempts_used
);

  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    PH_ST_A = 20'h00002,
    PH_ST_B = 20'h00004,
    PH_ST_C = 20'h00008,
    PH_ST_D = 20'h00010,
    PH_WB_A = 20'h00020,
    PH_WB_B = 20'h00040,
    PH_WB_C = 20'h00080,
    PH_AK_A = 20'h00100,
    PH_AK_B = 20'h00200,
    PH_AK_C = 20'h00400,
    PH_RB_A = 20'h00800,
    PH_RB_B = 20'h01000,
    PH_RB_C = 20'h02000,
    PH_NK_A = 20'h04000,
    PH_NK_B = 20'h08000,
    PH_NK_C = 20'h10000,
    PH_SP_A = 20'h20000,
    PH_SP_B = 20'h40000,
    PH_SP_C = 20'h80000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] counter, counter_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift, shift_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [5:0]  attempt, attempt_next;
  logic        is_read, is_read_next;
  logic        in_read, in_read_next;
  logic [6:0]  saved_device, saved_device_next;
  logic [7:0]  saved_reg, saved_reg_next;
  logic [7:0]  saved_data, saved_data_next;
  logic [7:0]  read_byte, read_byte_next;
  logic        last_acked, last_acked_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        done_next;
  logic        enter_en;
  logic [15:0] counter_dec;
  logic [15:0] counter_load;
  logic [1:0]  next_index;
  logic [1:0]  phase_bytes;
  logic [7:0]  next_byte;

  assign pop = nonempty && (!res_valid || !res_stall);

  assign counter_dec  = (counter != 16'd0) ? counter - 16'd1 : 16'd0;
  assign counter_load = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;

  // Byte that follows an acknowledged byte, and how many bytes the phase has.
  always_comb begin
    next_index  = byte_index + 2'd1;
    phase_bytes = in_read ? 2'd1 : (is_read ? 2'd2 : 2'd3);
    if (in_read) begin
      next_byte = {saved_device, 1'b1};
    end else if (next_index == 2'd0) begin
      next_byte = {saved_device, 1'b0};
    end else if (next_index == 2'd1) begin
      next_byte = saved_reg;
    end else begin
      next_byte = saved_data;
    end
  end

  always_comb begin
    phase_next        = phase;
    counter_next      = counter;
    bit_count_next    = bit_count;
    shift_next        = shift;
    byte_index_next   = byte_index;
    attempt_next      = attempt;
    is_read_next      = is_read;
    in_read_next      = in_read;
    saved_device_next = saved_device;
    saved_reg_next    = saved_reg;
    saved_data_next   = saved_data;
    read_byte_next    = read_byte;
    last_acked_next   = last_acked;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    done_next         = 1'b0;
    enter_en          = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.start) begin
        is_read_next      = item.read;
        in_read_next      = 1'b0;
        saved_device_next = item.device_addr;
        saved_reg_next    = item.reg_addr;
        saved_data_next   = item.write_data;
        if (item.read) begin
          read_byte_next = 8'd0;
        end
        attempt_next    = 6'd1;
        byte_index_next = 2'd0;
        bit_count_next  = 4'd0;
        phase_next      = PH_ST_A;
        enter_en        = 1'b1;
      end
    end else begin
      counter_next = counter_dec;
      if (counter_dec == 16'd0) begin
        enter_en = 1'b1;
        case (phase)
          PH_ST_A: phase_next = PH_ST_B;
          PH_ST_B: phase_next = PH_ST_C;
          PH_ST_C: phase_next = PH_ST_D;
          PH_ST_D: begin
            byte_index_next = 2'd0;
            shift_next      = in_read ? {saved_device, 1'b1} : {saved_device, 1'b0};
            bit_count_next  = 4'd0;
            phase_next      = PH_WB_A;
          end
          PH_WB_A: phase_next = PH_WB_B;
          PH_WB_B: phase_next = PH_WB_C;
          PH_WB_C: begin
            shift_next     = {shift[6:0], 1'b0};
            bit_count_next = bit_count + 4'd1;
            phase_next     = (bit_count_next >= 4'd8) ? PH_AK_A : PH_WB_A;
          end
          PH_AK_A: phase_next = PH_AK_B;
          PH_AK_B: begin
            last_acked_next = !item.sda_in;
            phase_next      = PH_AK_C;
          end
          PH_AK_C: begin
            if (!last_acked) begin
              phase_next = PH_SP_A;
            end else begin
              byte_index_next = next_index;
              if (next_index < phase_bytes) begin
                shift_next     = next_byte;
                bit_count_next = 4'd0;
                phase_next     = PH_WB_A;
              end else if (!is_read) begin
                phase_next = PH_SP_A;
              end else if (!in_read) begin
                in_read_next = 1'b1;
                attempt_next = 6'd1;
                phase_next   = PH_ST_A;
              end else begin
                shift_next     = 8'd0;
                bit_count_next = 4'd0;
                phase_next     = PH_RB_A;
              end
            end
          end
          PH_RB_A: phase_next = PH_RB_B;
          PH_RB_B: begin
            shift_next = {shift[6:0], item.sda_in};
            phase_next = PH_RB_C;
          end
          PH_RB_C: begin
            bit_count_next = bit_count + 4'd1;
            if (bit_count_next >= 4'd8) begin
              read_byte_next = shift;
              phase_next     = PH_NK_A;
            end else begin
              phase_next = PH_RB_A;
            end
          end
          PH_NK_A: phase_next = PH_NK_B;
          PH_NK_B: phase_next = PH_NK_C;
          PH_NK_C: phase_next = PH_SP_A;
          PH_SP_A: phase_next = PH_SP_B;
          PH_SP_B: phase_next = PH_SP_C;
          PH_SP_C: begin
            // A failed read address phase still moves on to the read phase.
            if (last_acked) begin
              phase_next = PH_IDLE;
              enter_en   = 1'b0;
              done_next  = 1'b1;
            end else if (attempt < cfg.max_attempts) begin
              attempt_next = attempt + 6'd1;
              phase_next   = PH_ST_A;
            end else if (is_read && !in_read) begin
              in_read_next = 1'b1;
              attempt_next = 6'd1;
              phase_next   = PH_ST_A;
            end else begin
              phase_next = PH_IDLE;
              enter_en   = 1'b0;
              done_next  = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            enter_en   = 1'b0;
          end
        endcase
      end
    end

    // Entering a phase restarts its timer and sets the pin it owns.
    if (enter_en) begin
      counter_next = counter_load;
      case (phase_next)
        PH_ST_A, PH_AK_A, PH_RB_A, PH_NK_A, PH_SP_C: sda_level_next = 1'b1;
        PH_ST_C, PH_SP_A:                            sda_level_next = 1'b0;
        PH_WB_A:                                     sda_level_next = shift_next[7];
        PH_ST_B, PH_WB_B, PH_AK_B, PH_RB_B, PH_NK_B, PH_SP_B: scl_level_next = 1'b1;
        PH_ST_D, PH_WB_C, PH_AK_C, PH_RB_C, PH_NK_C:          scl_level_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      counter      <= 16'd0;
      bit_count    <= 4'd0;
      shift        <= 8'd0;
      byte_index   <= 2'd0;
      attempt      <= 6'd0;
      is_read      <= 1'b0;
      in_read      <= 1'b0;
      saved_device <= 7'd0;
      saved_reg    <= 8'd0;
      saved_data   <= 8'd0;
      read_byte    <= 8'd0;
      last_acked   <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
    end else if (pop) begin
      phase        <= phase_next;
      counter      <= counter_next;
      bit_count    <= bit_count_next;
      shift        <= shift_next;
      byte_index   <= byte_index_next;
      attempt      <= attempt_next;
      is_read      <= is_read_next;
      in_read      <= in_read_next;
      saved_device <= saved_device_next;
      saved_reg    <= saved_reg_next;
      saved_data   <= saved_data_next;
      read_byte    <= read_byte_next;
      last_acked   <= last_acked_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_out       <= scl_level_next;
      sda_out       <= sda_level_next;
      busy_res      <= (phase_next != PH_IDLE);
      done_res      <= done_next;
      acked         <= last_acked_next;
      read_data     <= read_byte_next;
      attempts_used <= attempt_next;
    end
  end

endmodule

// ----- rtl/i2c_register_access_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_access_master
// I2C master that writes or reads one device register, with retry on NACK.
// ----------------------------------------------------------------------------
// Every transfer on the request channel is one bus tick and yields exactly one
// transfer on the result channel, in order. The block takes one tick per clock
// cycle for as long as the result side keeps up: the sequencer advances its
// whole bus state by one tick per popped item, and a four-entry queue plus
// an output register absorb short stalls on either side. An accepted tick
// passes the input register and from there goes through
// the queue, and the output register then holds its result. The bus timing is
// set by phase_ticks, counted in ticks rather than clock cycles. Configuration
// registers sit at byte address 0 (max_attempts) and 4 (phase_ticks); write
// them only while no transaction is in flight.
module i2c_register_access_master (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [6:0]  device_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  // Result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic        acked,
  output logic [7:0]  read_data,
  output logic [5:0]  attempts_used
);

  i2cra_pkg::cfg_t  cfg;
  i2cra_pkg::item_t push_item;
  i2cra_pkg::item_t head;
  logic             push;
  logic             queue_full;
  logic             nonempty;
  logic             pop;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts <= i2cra_pkg::MAX_ATTEMPTS_RESET;
      cfg.phase_ticks  <= i2cra_pkg::PHASE_TICKS_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        i2cra_pkg::REG_MAX_ATTEMPTS: cfg.max_attempts <= pwdata[5:0];
        i2cra_pkg::REG_PHASE_TICKS:  cfg.phase_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      i2cra_pkg::REG_MAX_ATTEMPTS: prdata = {26'd0, cfg.max_attempts};
      i2cra_pkg::REG_PHASE_TICKS:  prdata = {16'd0, cfg.phase_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

  i2cra_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .device_addr (device_addr),
    .reg_addr    (reg_addr),
    .write_data  (write_data),
    .sda_in      (sda_in),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  i2cra_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  i2cra_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .nonempty      (nonempty),
    .item          (head),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .scl_out       (scl_out),
    .sda_out       (sda_out),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .acked         (acked),
    .read_data     (read_data),
    .attempts_used (attempts_used)
  );

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the I2C register access master one bus tick per transfer and checks
// every result transfer against a tick-accurate model of the bus sequencer.
// The device side answers acknowledge and read-bit samples from the model's
// view of the bus, so writes, reads, NACK retries and exhausted attempts are
// all reached under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         RUN_LIMIT  = 200_000;
  localparam int         DRAIN_WAIT = 10;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       acked;
    logic [7:0] rdata;
    logic [5:0] attempts;
  } bus_view_t;

  typedef enum logic [19:0] {
    BP_IDLE         = 20'h00001,
    BP_START_SDA_HI = 20'h00002,
    BP_START_SCL_HI = 20'h00004,
    BP_START_SDA_LO = 20'h00008,
    BP_START_SCL_LO = 20'h00010,
    BP_BIT_SDA      = 20'h00020,
    BP_BIT_SCL_HI   = 20'h00040,
    BP_BIT_SCL_LO   = 20'h00080,
    BP_ACK_SDA_REL  = 20'h00100,
    BP_ACK_SCL_HI   = 20'h00200,
    BP_ACK_SCL_LO   = 20'h00400,
    BP_RD_SDA_REL   = 20'h00800,
    BP_RD_SCL_HI    = 20'h01000,
    BP_RD_SCL_LO    = 20'h02000,
    BP_NAK_SDA_REL  = 20'h04000,
    BP_NAK_SCL_HI   = 20'h08000,
    BP_NAK_SCL_LO   = 20'h10000,
    BP_STOP_SDA_LO  = 20'h20000,
    BP_STOP_SCL_HI  = 20'h40000,
    BP_STOP_SDA_HI  = 20'h80000
  } bus_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  op = i2cra_pkg::OP_TICK;
  logic [6:0]  device_addr = '0;
  logic [7:0]  reg_addr = '0;
  logic [7:0]  write_data = '0;
  logic        sda_in = 1'b1;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic        acked;
  logic [7:0]  read_data;
  logic [5:0]  attempts_used;

  i2c_register_access_master u_top (.*);

  always #2 clk = ~clk;

  // Sequencer model state and its copy of the configuration.
  logic [5:0]  cfg_max_attempts = i2cra_pkg::MAX_ATTEMPTS_RESET;
  logic [15:0] cfg_phase_ticks  = i2cra_pkg::PHASE_TICKS_RESET;
  bus_phase_t  bus_phase   = BP_IDLE;
  logic [15:0] ph_count    = '0;
  logic [3:0]  bit_cnt     = '0;
  logic [7:0]  shifter     = '0;
  logic [1:0]  byte_idx    = '0;
  logic [5:0]  attempt_cnt = '0;
  logic        txn_read    = 1'b0;
  logic        read_stage  = 1'b0;
  logic [6:0]  dev_q       = '0;
  logic [7:0]  regaddr_q   = '0;
  logic [7:0]  data_q      = '0;
  logic [7:0]  rx_byte     = '0;
  logic        ack_seen    = 1'b0;
  logic        scl_q       = 1'b1;
  logic        sda_q       = 1'b1;

  tick_t     ticks_to_send[$];
  bus_view_t bus_view_q[$];
  int        ticks_queued = 0;
  int        ticks_taken  = 0;
  int        err_count    = 0;
  int        cycle_count  = 0;
  int        nack_pct     = 0;
  bit        tick_taken   = 1'b0;
  bit        hold_req     = 1'b0;

  task enter_phase(input bus_phase_t p);
    bus_phase = p;
    ph_count  = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
    case (p)
      BP_START_SDA_HI, BP_ACK_SDA_REL, BP_RD_SDA_REL, BP_NAK_SDA_REL,
      BP_STOP_SDA_HI: sda_q = 1'b1;
      BP_START_SDA_LO, BP_STOP_SDA_LO: sda_q = 1'b0;
      BP_BIT_SDA: sda_q = shifter[7];
      BP_START_SCL_HI, BP_BIT_SCL_HI, BP_ACK_SCL_HI, BP_RD_SCL_HI, BP_NAK_SCL_HI,
      BP_STOP_SCL_HI: scl_q = 1'b1;
      BP_START_SCL_LO, BP_BIT_SCL_LO, BP_ACK_SCL_LO, BP_RD_SCL_LO,
      BP_NAK_SCL_LO: scl_q = 1'b0;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] next_out_byte();
    if (read_stage) return {dev_q, 1'b1};
    if (byte_idx == 2'd0) return {dev_q, 1'b0};
    if (byte_idx == 2'd1) return regaddr_q;
    return data_q;
  endfunction

  function automatic int bytes_in_stage();
    if (read_stage) return 1;
    return txn_read ? 2 : 3;
  endfunction

  task load_byte();
    shifter = next_out_byte();
    bit_cnt = '0;
    enter_phase(BP_BIT_SDA);
  endtask

  // The read stage always restarts with a fresh attempt count.
  task open_read_stage();
    read_stage  = 1'b1;
    attempt_cnt = 6'd1;
    enter_phase(BP_START_SDA_HI);
  endtask

  task end_phase(input logic sda, output logic finished);
    finished = 1'b0;
    case (bus_phase)
      BP_START_SDA_HI: enter_phase(BP_START_SCL_HI);
      BP_START_SCL_HI: enter_phase(BP_START_SDA_LO);
      BP_START_SDA_LO: enter_phase(BP_START_SCL_LO);
      BP_START_SCL_LO: begin
        byte_idx = '0;
        load_byte();
      end
      BP_BIT_SDA:    enter_phase(BP_BIT_SCL_HI);
      BP_BIT_SCL_HI: enter_phase(BP_BIT_SCL_LO);
      BP_BIT_SCL_LO: begin
        shifter = shifter << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) enter_phase(BP_ACK_SDA_REL);
        else enter_phase(BP_BIT_SDA);
      end
      BP_ACK_SDA_REL: enter_phase(BP_ACK_SCL_HI);
      BP_ACK_SCL_HI: begin
        ack_seen = !sda;
        enter_phase(BP_ACK_SCL_LO);
      end
      BP_ACK_SCL_LO: begin
        if (!ack_seen) begin
          enter_phase(BP_STOP_SDA_LO);
        end else begin
          byte_idx = byte_idx + 2'd1;
          if (int'(byte_idx) < bytes_in_stage()) load_byte();
          else if (!txn_read) enter_phase(BP_STOP_SDA_LO);
          else if (!read_stage) open_read_stage();
          else begin
            shifter = '0;
            bit_cnt = '0;
            enter_phase(BP_RD_SDA_REL);
          end
        end
      end
      BP_RD_SDA_REL: enter_phase(BP_RD_SCL_HI);
      BP_RD_SCL_HI: begin
        shifter = {shifter[6:0], sda};
        enter_phase(BP_RD_SCL_LO);
      end
      BP_RD_SCL_LO: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          rx_byte = shifter;
          enter_phase(BP_NAK_SDA_REL);
        end else begin
          enter_phase(BP_RD_SDA_REL);
        end
      end
      BP_NAK_SDA_REL: enter_phase(BP_NAK_SCL_HI);
      BP_NAK_SCL_HI:  enter_phase(BP_NAK_SCL_LO);
      BP_NAK_SCL_LO:  enter_phase(BP_STOP_SDA_LO);
      BP_STOP_SDA_LO: enter_phase(BP_STOP_SCL_HI);
      BP_STOP_SCL_HI: enter_phase(BP_STOP_SDA_HI);
      BP_STOP_SDA_HI: begin
        if (ack_seen) begin
          bus_phase = BP_IDLE;
          finished  = 1'b1;
        end else if (attempt_cnt < cfg_max_attempts) begin
          attempt_cnt = attempt_cnt + 6'd1;
          enter_phase(BP_START_SDA_HI);
        end else if (txn_read && !read_stage) begin
          // A read goes on to its data stage even when the address never got through.
          open_read_stage();
        end else begin
          bus_phase = BP_IDLE;
          finished  = 1'b1;
        end
      end
      default: bus_phase = BP_IDLE;
    endcase
  endtask

  task advance_bus_tick(input tick_t t, output bus_view_t v);
    logic finished;
    finished = 1'b0;
    if (bus_phase == BP_IDLE) begin
      if (t.op == i2cra_pkg::OP_WRITE || t.op == i2cra_pkg::OP_READ) begin
        txn_read    = (t.op == i2cra_pkg::OP_READ);
        read_stage  = 1'b0;
        dev_q       = t.device_addr;
        regaddr_q   = t.reg_addr;
        data_q      = t.write_data;
        if (txn_read) rx_byte = '0;
        attempt_cnt = 6'd1;
        byte_idx    = '0;
        bit_cnt     = '0;
        enter_phase(BP_START_SDA_HI);
      end
    end else begin
      if (ph_count > 16'd0) ph_count = ph_count - 16'd1;
      if (ph_count == 16'd0) end_phase(t.sda_in, finished);
    end
    v = {scl_q, sda_q, bus_phase != BP_IDLE, finished, ack_seen, rx_byte, attempt_cnt};
  endtask

  function automatic string fmt_view(input bus_view_t v);
    return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b ack=%0b rdata=%02h attempts=%0d",
                     v.scl, v.sda, v.busy, v.done, v.acked, v.rdata, v.attempts);
  endfunction

  task note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Result check first, then the model takes the tick accepted at this edge.
  bus_view_t got_view, want_view;
  tick_t     taken_tick;
  always @(posedge clk) begin
    if (rst) begin
      tick_taken = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got_view = {scl_out, sda_out, busy_res, done_res, acked, read_data, attempts_used};
        if (bus_view_q.size() == 0) begin
          note_error({"result with none expected: ", fmt_view(got_view)});
        end else begin
          want_view = bus_view_q.pop_front();
          if (got_view !== want_view)
            note_error({"expected ", fmt_view(want_view), " got ", fmt_view(got_view)});
        end
      end
      tick_taken = req_valid && !req_stall;
      if (tick_taken) begin
        taken_tick = {op, device_addr, reg_addr, write_data, sda_in};
        advance_bus_tick(taken_tick, want_view);
        bus_view_q.push_back(want_view);
        ticks_taken++;
      end
    end
  end

  // Request driver. The device side of the bus is played here: on the tick
  // that samples an acknowledge or a read bit, SDA is answered from the model.
  tick_t drv_tick;
  int    tx_gap  = 0;
  bit    tx_calm = 1'b0;
  int    tx_roll;
  always @(negedge clk) begin
    if (!rst && (!req_valid || tick_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        req_valid <= 1'b0;
      end else if (ticks_to_send.size() > 0) begin
        drv_tick = ticks_to_send.pop_front();
        if (bus_phase == BP_ACK_SCL_HI && ph_count <= 16'd1)
          drv_tick.sda_in = ($urandom_range(0, 99) < nack_pct);
        else if (bus_phase == BP_RD_SCL_HI && ph_count <= 16'd1)
          drv_tick.sda_in = 1'($urandom_range(0, 1));
        op          <= drv_tick.op;
        device_addr <= drv_tick.device_addr;
        reg_addr    <= drv_tick.reg_addr;
        write_data  <= drv_tick.write_data;
        sda_in      <= drv_tick.sda_in;
        req_valid   <= 1'b1;
        if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;
        tx_roll = $urandom_range(0, 99);
        if (tx_calm || tx_roll < 70) tx_gap = 0;
        else if (tx_roll < 95) tx_gap = $urandom_range(1, 3);
        else tx_gap = $urandom_range(10, 50);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result side stalls, with one long hold-off when requested.
  int rx_gap      = 0;
  int hold_left   = 0;
  bit hold_started = 1'b0;
  bit rx_calm     = 1'b0;
  int rx_roll;
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = 400;
      res_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (rx_calm) begin
        res_stall <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_stall <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 75) begin
          res_stall <= 1'b0;
        end else begin
          res_stall <= 1'b1;
          rx_gap = (rx_roll < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tick_t rand_tick(input logic allow_req);
    tick_t t;
    int    r;
    r = $urandom_range(0, 99);
    t.device_addr = 7'($urandom);
    t.reg_addr    = 8'($urandom);
    t.write_data  = 8'($urandom);
    t.sda_in      = 1'($urandom);
    if (r < 80) t.op = i2cra_pkg::OP_TICK;
    else if (r < 90 || !allow_req) t.op = OP_UNUSED;
    else if (r < 95) t.op = i2cra_pkg::OP_WRITE;
    else t.op = i2cra_pkg::OP_READ;
    return t;
  endfunction

  task push_tick(input tick_t t);
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  task push_idle(input int n);
    for (int i = 0; i < n; i++) push_tick(rand_tick(1'b0));
  endtask

  // Queues one request and keeps the bus ticking until the model is idle
  // again. Extra requests mixed into the ticks are ignored while busy.
  task run_txn(input logic [1:0] kind, input logic [6:0] dev, input logic [7:0] ra,
               input logic [7:0] wd, input int nack);
    tick_t t;
    nack_pct = nack;
    t = rand_tick(1'b0);
    t.op          = kind;
    t.device_addr = dev;
    t.reg_addr    = ra;
    t.write_data  = wd;
    push_tick(t);
    @(negedge clk);
    while (ticks_taken != ticks_queued || bus_phase != BP_IDLE) begin
      if (bus_phase != BP_IDLE && ticks_queued - ticks_taken < 3) push_tick(rand_tick(1'b1));
      @(negedge clk);
    end
  endtask

  task wait_drained(input logic need_idle);
    while (ticks_taken != ticks_queued || bus_view_q.size() != 0 ||
           (need_idle && bus_phase != BP_IDLE))
      @(negedge clk);
  endtask

  task apb_write(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == i2cra_pkg::REG_MAX_ATTEMPTS) cfg_max_attempts = val[5:0];
    else cfg_phase_ticks = val[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task apb_read_check(input logic [0:0] idx, input logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      note_error($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task configure(input logic [5:0] attempts, input logic [15:0] ticks);
    wait_drained(1'b1);
    apb_write(i2cra_pkg::REG_MAX_ATTEMPTS, {26'd0, attempts});
    apb_write(i2cra_pkg::REG_PHASE_TICKS, {16'd0, ticks});
    apb_read_check(i2cra_pkg::REG_MAX_ATTEMPTS, {26'd0, attempts});
    apb_read_check(i2cra_pkg::REG_PHASE_TICKS, {16'd0, ticks});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_read_check(i2cra_pkg::REG_MAX_ATTEMPTS, {26'd0, i2cra_pkg::MAX_ATTEMPTS_RESET});
    apb_read_check(i2cra_pkg::REG_PHASE_TICKS, {16'd0, i2cra_pkg::PHASE_TICKS_RESET});

    // Directed: field extremes, both operations, NACK retries that run out.
    configure(6'd2, 16'd1);
    push_idle(3);
    run_txn(i2cra_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 0);
    // The result side holds off for a long stretch while this read runs.
    hold_req = 1'b1;
    run_txn(i2cra_pkg::OP_READ, 7'h2A, 8'h5A, 8'hA5, 0);
    run_txn(i2cra_pkg::OP_WRITE, 7'h13, 8'h80, 8'h01, 100);
    run_txn(i2cra_pkg::OP_READ, 7'h50, 8'h01, 8'h80, 100);
    push_idle(4);

    // A zero attempt limit still makes one attempt; zero ticks act as one.
    configure(6'd0, 16'd0);
    run_txn(i2cra_pkg::OP_WRITE, 7'h00, 8'h00, 8'h00, 100);
    run_txn(i2cra_pkg::OP_READ, 7'h40, 8'h33, 8'hCC, 50);

    // Longest phase: only the opening ticks of a transaction fit in the run.
    configure(6'd63, 16'hFFFF);
    push_tick('{op: i2cra_pkg::OP_READ, device_addr: 7'h7F, reg_addr: 8'hFF,
                write_data: 8'hFF, sda_in: 1'b1});
    for (int i = 0; i < 40; i++) push_tick(rand_tick(1'b1));

    wait_drained(1'b0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_count == 0 && bus_view_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
